### src/assert_macros.svh
// Assertion helpers used by the switch gesture decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every rising edge outside reset.
`define SGD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("switch gesture decoder check failed");

// An antecedent that implies a consequent in the following cycle.
`define SGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("switch gesture decoder check failed");

`endif

### src/sgd_pkg.sv
package sgd_pkg;

  // Gesture modes of the decoder.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_HOLD  = 3'd1,
    MODE_HELD  = 3'd2,
    MODE_WAIT  = 3'd3,
    MODE_DBL   = 3'd4,
    MODE_AFTER = 3'd5
  } mode_t;

  // Blind commands.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_OPEN      = 3'd1,
    CMD_CLOSE     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_OPEN_ALL  = 3'd4,
    CMD_CLOSE_ALL = 3'd5,
    CMD_STOP_ALL  = 3'd6
  } cmd_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SWAP      = 3'd0,
    REG_UP_LEVEL  = 3'd1,
    REG_DN_LEVEL  = 3'd2,
    REG_HOLD      = 3'd3,
    REG_CLICK     = 3'd4,
    REG_TIMEOUT   = 3'd5,
    REG_CHANNEL   = 3'd6
  } reg_idx_t;

  // Configuration as seen by the decoder core.
  typedef struct packed {
    logic        switch_swap;
    logic        up_active_level;
    logic        down_active_level;
    logic [9:0]  hold_ticks;
    logic [9:0]  click_ticks;
    logic [15:0] timeout_ticks;
    logic [3:0]  channel_number;
  } cfg_t;

  // Pressed state of a role: dir 1 is the up role, 0 the down role.
  function automatic logic role_pressed(input logic dir, input cfg_t cfg,
                                        input logic up, input logic down);
    logic up_on;
    logic down_on;
    up_on   = (up == cfg.up_active_level);
    down_on = (down == cfg.down_active_level);
    if (cfg.switch_swap) begin
      return dir ? down_on : up_on;
    end
    return dir ? up_on : down_on;
  endfunction

endpackage

### src/switch_gesture_decoder.sv
// Switch gesture decoder.
// Each input transaction on the s_ channel is one polling tick carrying the
// raw up and down switch levels; each tick yields exactly one result
// transaction on the m_ channel with the command, the target channel and a
// busy flag. Registers are to be written over the APB port only while the
// block is idle; the block does not enforce this. A result is presented in
// the cycle after its tick is accepted. Throughput: one tick per cycle while
// the receiver takes results; the whole gesture step is a single pass of
// logic from the state registers into the result register. When the
// receiver stalls, the result register holds its transaction and s_tready
// stays high only if that register is being emptied in the same cycle, so
// no result is lost or repeated. Reset is synchronous: the gesture state
// returns to idle with the up switch checked first, the registers return to
// their defaults and no result is pending.
`include "assert_macros.svh"

module switch_gesture_decoder
  import sgd_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [0] up_level, [1] down_level, [7:2] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // m_tdata: [2:0] command, [6:3] target_channel, [7] busy_res
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  logic  busy;
  mode_t mode;
  logic  accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  sgd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .up_level   (s_tdata[0]),
    .down_level (s_tdata[1]),
    .cfg        (cfg),
    .cmd        (cmd),
    .busy       (busy),
    .mode       (mode)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {busy, cfg.channel_number, cmd};
    end
  end

  // An accepted tick always leaves a result pending.
  `SGD_ASSERT_NEXT(a_result_pending, clk, rst, accept, m_tvalid)

  // The busy flag of a fresh result matches the stored gesture mode.
  `SGD_ASSERT_NEXT(a_busy_mode, clk, rst, accept, m_tdata[7] == (mode != MODE_IDLE))

  // Open and close only start a gesture, which then waits out the hold time.
  `SGD_ASSERT_NEXT(a_press_starts_hold, clk, rst,
                   accept && (cmd == CMD_OPEN || cmd == CMD_CLOSE),
                   mode == MODE_HOLD)

  // A gesture can only start from idle.
  `SGD_ASSERT(a_start_from_idle, clk, rst,
              (cmd == CMD_OPEN || cmd == CMD_CLOSE) |-> mode == MODE_IDLE)

endmodule

### src/sgd_regs.sv
module sgd_regs
  import sgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = regs;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.switch_swap       <= 1'b0;
      regs.up_active_level   <= 1'b0;
      regs.down_active_level <= 1'b0;
      regs.hold_ticks        <= 10'd10;
      regs.click_ticks       <= 10'd5;
      regs.timeout_ticks     <= 16'd600;
      regs.channel_number    <= 4'd0;
    end else if (wr) begin
      unique case (idx)
        REG_SWAP:     regs.switch_swap       <= pwdata[0];
        REG_UP_LEVEL: regs.up_active_level   <= pwdata[0];
        REG_DN_LEVEL: regs.down_active_level <= pwdata[0];
        REG_HOLD:     regs.hold_ticks        <= pwdata[9:0];
        REG_CLICK:    regs.click_ticks       <= pwdata[9:0];
        REG_TIMEOUT:  regs.timeout_ticks     <= pwdata[15:0];
        REG_CHANNEL:  regs.channel_number    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_SWAP:     prdata = {31'd0, regs.switch_swap};
      REG_UP_LEVEL: prdata = {31'd0, regs.up_active_level};
      REG_DN_LEVEL: prdata = {31'd0, regs.down_active_level};
      REG_HOLD:     prdata = {22'd0, regs.hold_ticks};
      REG_CLICK:    prdata = {22'd0, regs.click_ticks};
      REG_TIMEOUT:  prdata = {16'd0, regs.timeout_ticks};
      REG_CHANNEL:  prdata = {28'd0, regs.channel_number};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

### src/sgd_core.sv
module sgd_core
  import sgd_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  logic  up_level,
  input  logic  down_level,
  input  cfg_t  cfg,
  output cmd_t  cmd,
  output logic  busy,
  output mode_t mode
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  phase, phase_next;
  logic                  dbl, dbl_next;
  logic                  dir, dir_next;
  logic [COUNT_BITS-1:0] count, count_next;
  mode_t                 mode_next;

  logic                  pr_dir, pr_oth, pr_phase;
  logic [COUNT_BITS-1:0] inc, w_cnt, w_inc;
  logic                  w_dbl;
  logic [CMP_W-1:0]      hold_len;

  // Pressed states for the gesture's own role, the other role and the idle check.
  assign pr_dir   = role_pressed(dir, cfg, up_level, down_level);
  assign pr_oth   = role_pressed(!dir, cfg, up_level, down_level);
  assign pr_phase = role_pressed(phase, cfg, up_level, down_level);

  // Saturating increments of the current count and of the count the wait starts from.
  assign inc      = (&count) ? count : count + 1'b1;
  assign w_cnt    = (mode == MODE_WAIT) ? count : '0;
  assign w_dbl    = (mode == MODE_HOLD) ? 1'b0 : dbl;
  assign w_inc    = (&w_cnt) ? w_cnt : w_cnt + 1'b1;
  assign hold_len = (cfg.hold_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.hold_ticks);

  // Next state and command for one tick.
  always_comb begin
    logic go_wait;
    mode_next  = mode;
    phase_next = phase;
    count_next = count;
    dbl_next   = dbl;
    dir_next   = dir;
    cmd        = CMD_NONE;
    go_wait    = 1'b0;

    unique case (mode)
      MODE_IDLE: begin
        phase_next = !phase;
        if (pr_phase) begin
          dir_next   = phase;
          mode_next  = MODE_HOLD;
          count_next = '0;
          dbl_next   = 1'b0;
          cmd        = phase ? CMD_OPEN : CMD_CLOSE;
        end
      end
      MODE_HOLD: begin
        count_next = inc;
        if (CMP_W'(inc) >= hold_len) begin
          if (pr_dir) begin
            mode_next = MODE_HELD;
          end else begin
            go_wait = 1'b1;
          end
        end
      end
      MODE_HELD: begin
        if (!pr_dir) begin
          mode_next = MODE_IDLE;
          cmd       = CMD_STOP;
        end
      end
      MODE_WAIT: begin
        go_wait = 1'b1;
      end
      MODE_DBL, MODE_AFTER: begin
        count_next = inc;
        if (CMP_W'(inc) >= hold_len) begin
          if (mode == MODE_DBL) begin
            go_wait = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    // One tick of waiting for another press.
    if (go_wait) begin
      priority if (pr_dir) begin
        count_next = '0;
        if (w_dbl || CMP_W'(w_cnt) >= CMP_W'(cfg.click_ticks)) begin
          mode_next = MODE_AFTER;
          dbl_next  = w_dbl;
          cmd       = w_dbl ? CMD_STOP_ALL : CMD_STOP;
        end else begin
          mode_next = MODE_DBL;
          dbl_next  = 1'b1;
          cmd       = dir ? CMD_OPEN_ALL : CMD_CLOSE_ALL;
        end
      end else if (pr_oth) begin
        count_next = '0;
        mode_next  = MODE_AFTER;
        dbl_next   = w_dbl;
        cmd        = w_dbl ? CMD_STOP_ALL : CMD_STOP;
      end else begin
        count_next = w_inc;
        dbl_next   = w_dbl;
        mode_next  = (CMP_W'(w_inc) >= CMP_W'(cfg.timeout_ticks)) ? MODE_IDLE : MODE_WAIT;
      end
    end

    // A finished gesture hands the next idle check to the other switch.
    if (mode_next == MODE_IDLE && cmd != CMD_NONE && cmd != CMD_OPEN && cmd != CMD_CLOSE) begin
      phase_next = !dir_next;
    end
  end

  assign busy = (mode_next != MODE_IDLE);

  // State registers, advanced once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      phase <= 1'b1;
      count <= '0;
      dbl   <= 1'b0;
      dir   <= 1'b0;
    end else if (step) begin
      mode  <= mode_next;
      phase <= phase_next;
      count <= count_next;
      dbl   <= dbl_next;
      dir   <= dir_next;
    end
  end

endmodule

### bench/tb_switch_gesture_decoder.sv
`timescale 1ns / 1ps

module tb_switch_gesture_decoder;
  import sgd_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PLAN_ROWS   = 35;
  localparam int LONG_STALL  = 300;

  // One result transaction as the decoder should produce it.
  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] chan;
    logic       busy;
  } gesture_res_t;

  // Register contents as the decoder should currently see them.
  typedef struct {
    logic        swap;
    logic        up_lvl;
    logic        dn_lvl;
    logic [9:0]  hold;
    logic [9:0]  click;
    logic [15:0] tmo;
    logic [3:0]  chan;
  } switch_cfg_t;

  // A row of the directed plan: either a register write or a tick.
  typedef struct packed {
    logic         is_cfg;
    reg_idx_t     ridx;
    logic [15:0]  val;
    logic         up;
    logic         dn;
    logic         typed;
    gesture_res_t fixed;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted decoder state and register copy, both at their reset values.
  switch_cfg_t cfg = '{1'b0, 1'b0, 1'b0, 10'd10, 10'd5, 16'd600, 4'd0};
  mode_t       dec_mode = MODE_IDLE;
  logic        dec_phase = 1'b1;
  logic [15:0] dec_count = '0;
  logic        dec_double = 1'b0;
  logic        dec_dir = 1'b0;

  gesture_res_t due_results[$];
  plan_row_t    plan [PLAN_ROWS];

  int errors = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int settings_done = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int cmd_seen [8] = '{default: 0};

  // Receiver stall control.
  int          stall_asks = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  logic [15:0] ready_pat = '1;
  int          pat_pos = 0;

  switch_gesture_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Pressed state of a role (1 is the up role), after swapping and per-pin levels.
  function automatic logic role_held(logic dir, logic up, logic dn);
    logic up_on;
    logic dn_on;
    up_on = (up == cfg.up_lvl);
    dn_on = (dn == cfg.dn_lvl);
    if (cfg.swap) begin
      return dir ? dn_on : up_on;
    end
    return dir ? up_on : dn_on;
  endfunction

  // The tick counter saturates rather than wrapping.
  function automatic void bump_count();
    if (dec_count != 16'hFFFF) begin
      dec_count = dec_count + 16'd1;
    end
  endfunction

  // A hold time of zero behaves as one tick.
  function automatic logic [15:0] hold_span();
    return (cfg.hold == 0) ? 16'd1 : 16'(cfg.hold);
  endfunction

  // One tick spent waiting for a further press after a short click.
  function automatic cmd_t await_press(logic up, logic dn);
    if (role_held(dec_dir, up, dn)) begin
      if (dec_double || dec_count >= 16'(cfg.click)) begin
        dec_mode  = MODE_AFTER;
        dec_count = '0;
        return dec_double ? CMD_STOP_ALL : CMD_STOP;
      end
      dec_double = 1'b1;
      dec_count  = '0;
      dec_mode   = MODE_DBL;
      return dec_dir ? CMD_OPEN_ALL : CMD_CLOSE_ALL;
    end
    if (role_held(~dec_dir, up, dn)) begin
      dec_mode  = MODE_AFTER;
      dec_count = '0;
      return dec_double ? CMD_STOP_ALL : CMD_STOP;
    end
    bump_count();
    if (dec_count >= cfg.tmo) begin
      dec_mode = MODE_IDLE;
    end
    return CMD_NONE;
  endfunction

  // Advances the predicted state by one tick and returns the result it gives.
  function automatic gesture_res_t decode_tick(logic up, logic dn);
    cmd_t         cmd;
    logic         d;
    gesture_res_t res;
    cmd = CMD_NONE;
    case (dec_mode)
      MODE_IDLE: begin
        d = dec_phase;
        dec_phase = ~dec_phase;
        if (role_held(d, up, dn)) begin
          dec_dir    = d;
          dec_mode   = MODE_HOLD;
          dec_count  = '0;
          dec_double = 1'b0;
          cmd = d ? CMD_OPEN : CMD_CLOSE;
        end
      end
      MODE_HOLD: begin
        bump_count();
        if (dec_count >= hold_span()) begin
          if (role_held(dec_dir, up, dn)) begin
            dec_mode = MODE_HELD;
          end else begin
            dec_mode   = MODE_WAIT;
            dec_count  = '0;
            dec_double = 1'b0;
            cmd = await_press(up, dn);
          end
        end
      end
      MODE_HELD: begin
        if (!role_held(dec_dir, up, dn)) begin
          dec_mode = MODE_IDLE;
          cmd = CMD_STOP;
        end
      end
      MODE_WAIT: begin
        cmd = await_press(up, dn);
      end
      MODE_DBL: begin
        bump_count();
        if (dec_count >= hold_span()) begin
          dec_mode  = MODE_WAIT;
          dec_count = '0;
          cmd = await_press(up, dn);
        end
      end
      MODE_AFTER: begin
        bump_count();
        if (dec_count >= hold_span()) begin
          dec_mode = MODE_IDLE;
        end
      end
      default: begin
        dec_mode = MODE_IDLE;
      end
    endcase
    // A finished gesture hands the next idle check to the other switch.
    if (dec_mode == MODE_IDLE && cmd != CMD_NONE && cmd != CMD_OPEN && cmd != CMD_CLOSE) begin
      dec_phase = ~dec_dir;
    end
    res.cmd  = cmd;
    res.chan = cfg.chan;
    res.busy = (dec_mode != MODE_IDLE);
    return res;
  endfunction

  // Pin levels that put the up and down roles into the wanted pressed states.
  function automatic logic [1:0] pin_levels(logic up_role, logic dn_role);
    logic up_pin_on;
    logic dn_pin_on;
    up_pin_on = cfg.swap ? dn_role : up_role;
    dn_pin_on = cfg.swap ? up_role : dn_role;
    return {dn_pin_on ? cfg.dn_lvl : ~cfg.dn_lvl, up_pin_on ? cfg.up_lvl : ~cfg.up_lvl};
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_t r, logic [15:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.ridx = r;
    row.val = v;
    return row;
  endfunction

  function automatic plan_row_t tick_row(logic up, logic dn);
    plan_row_t row;
    row = '0;
    row.up = up;
    row.dn = dn;
    return row;
  endfunction

  function automatic plan_row_t check_row(logic up, logic dn, cmd_t c, logic [3:0] ch,
                                          logic b);
    plan_row_t row;
    row = tick_row(up, dn);
    row.typed = 1'b1;
    row.fixed = '{c, ch, b};
    return row;
  endfunction

  // Offers one tick in bursts separated by random gaps, then records its result.
  task automatic offer_tick(logic up, logic dn, logic typed = 1'b0,
                            gesture_res_t fixed = '0);
    int           gap;
    gesture_res_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, dn, up};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    res = decode_tick(up, dn);
    if (typed) begin
      res = fixed;
    end
    due_results.push_back(res);
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then the port returns to idle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SWAP:     cfg.swap   = val[0];
      REG_UP_LEVEL: cfg.up_lvl = val[0];
      REG_DN_LEVEL: cfg.dn_lvl = val[0];
      REG_HOLD:     cfg.hold   = val[9:0];
      REG_CLICK:    cfg.click  = val[9:0];
      REG_TIMEOUT:  cfg.tmo    = val[15:0];
      REG_CHANNEL:  cfg.chan   = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic swap, logic up_lvl, logic dn_lvl, int hold, int click,
                            int tmo, int chan);
    drain();
    write_reg(REG_SWAP, 32'(swap));
    write_reg(REG_UP_LEVEL, 32'(up_lvl));
    write_reg(REG_DN_LEVEL, 32'(dn_lvl));
    write_reg(REG_HOLD, 32'(hold));
    write_reg(REG_CLICK, 32'(click));
    write_reg(REG_TIMEOUT, 32'(tmo));
    write_reg(REG_CHANNEL, 32'(chan));
    settings_done++;
  endtask

  // Segments of steady switch states whose lengths straddle the hold, click
  // and timeout thresholds, with some segments of random levels mixed in.
  task automatic run_phase(int n);
    int         sent;
    int         len;
    int         i;
    int         pick;
    int         hl;
    int         click_cap;
    int         tmo_cap;
    logic       up_role;
    logic       dn_role;
    logic [1:0] lv;
    sent = 0;
    while (sent < n) begin
      hl = (cfg.hold == 0) ? 1 : int'(cfg.hold);
      click_cap = (cfg.click > 64) ? 64 : int'(cfg.click);
      tmo_cap = (cfg.tmo > 64) ? 64 : int'(cfg.tmo);
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, 4);
        1: len = hl - 1 + $urandom_range(0, 2);
        2: len = $urandom_range(1, click_cap + 2);
        default: len = $urandom_range(1, tmo_cap + 2);
      endcase
      if (len < 1) begin
        len = 1;
      end
      pick = $urandom_range(0, 19);
      up_role = (pick >= 8 && pick <= 12) || pick >= 18;
      dn_role = (pick >= 13);
      for (i = 0; i < len; i++) begin
        if (pick < 2) begin
          lv = 2'($urandom_range(0, 3));
        end else begin
          lv = pin_levels(up_role, dn_role);
        end
        offer_tick(lv[0], lv[1]);
      end
      sent += len;
    end
  endtask

  // Receiver: a rotating ready pattern, or a long hold-off when asked for one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      stall_left = LONG_STALL;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ready_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
      if (pat_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom | $urandom);
          default: ready_pat = 16'($urandom & $urandom) | 16'h0101;
        endcase
      end
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    gesture_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      cmd_seen[m_tdata[2:0]]++;
      if (due_results.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (m_tdata[2:0] != want.cmd) begin
          $display("%0t: command expected %0d, got %0d", $time, want.cmd, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[6:3] != want.chan) begin
          $display("%0t: target_channel expected %0d, got %0d", $time, want.chan,
                   m_tdata[6:3]);
          errors++;
        end
        if (m_tdata[7] != want.busy) begin
          $display("%0t: busy expected %0d, got %0d", $time, want.busy, m_tdata[7]);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int         k;
    logic [1:0] lv;
    logic [1:0] quiet;

    // Directed plan: reset behaviour, a held press, a double click ending in
    // stop all, a silent timeout, a late second press, then swapped roles with
    // an inverted up level and zero hold, click and timeout.
    plan = '{
      check_row(1'b1, 1'b1, CMD_NONE, 4'd0, 1'b0),
      cfg_row(REG_HOLD, 16'd1),
      cfg_row(REG_CLICK, 16'd2),
      cfg_row(REG_TIMEOUT, 16'd3),
      cfg_row(REG_CHANNEL, 16'd15),
      check_row(1'b0, 1'b1, CMD_NONE, 4'd15, 1'b0),
      check_row(1'b0, 1'b1, CMD_OPEN, 4'd15, 1'b1),
      tick_row(1'b0, 1'b1),
      check_row(1'b1, 1'b1, CMD_STOP, 4'd15, 1'b0),
      tick_row(1'b1, 1'b0),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b0),
      tick_row(1'b1, 1'b1),
      tick_row(1'b0, 1'b1),
      tick_row(1'b1, 1'b1),
      tick_row(1'b0, 1'b1),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b1),
      tick_row(1'b0, 1'b0),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b0),
      tick_row(1'b1, 1'b1),
      cfg_row(REG_SWAP, 16'd1),
      cfg_row(REG_UP_LEVEL, 16'd1),
      cfg_row(REG_DN_LEVEL, 16'd0),
      cfg_row(REG_HOLD, 16'd0),
      cfg_row(REG_CLICK, 16'd0),
      cfg_row(REG_TIMEOUT, 16'd0),
      tick_row(1'b1, 1'b1),
      tick_row(1'b1, 1'b0),
      tick_row(1'b0, 1'b0),
      tick_row(1'b0, 1'b1),
      tick_row(1'b1, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].ridx, 32'(plan[k].val));
      end else begin
        offer_tick(plan[k].up, plan[k].dn, plan[k].typed, plan[k].fixed);
      end
    end

    // Fixed settings, the extremes among them; the second one runs under a
    // long receiver hold-off so that the input side backs up.
    set_config(1'b0, 1'b0, 1'b0, 3, 4, 12, 5);
    run_phase(150);
    set_config(1'b1, 1'b1, 1'b0, 1, 0, 1, 15);
    stall_asks++;
    run_phase(150);
    set_config(1'b1, 1'b0, 1'b1, 0, 2, 0, 0);
    run_phase(100);
    set_config(1'b0, 1'b1, 1'b1, 5, 1023, 20, 9);
    run_phase(100);
    set_config(1'b0, 1'b0, 1'b1, 60, 3, 40, 6);
    run_phase(250);

    // Random small settings.
    for (k = 0; k < 6; k++) begin
      set_config($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                 $urandom_range(0, 1) == 1, $urandom_range(1, 8), $urandom_range(0, 10),
                 $urandom_range(0, 40), $urandom_range(0, 15));
      if (k == 3) begin
        stall_asks++;
      end
      run_phase(60);
    end

    // Longest timeout: two short presses followed by a quiet stretch far shorter
    // than the timeout, which must leave the wait running.
    set_config(1'b0, 1'b1, 1'b0, 2, 3, 65535, 3);
    quiet = pin_levels(1'b0, 1'b0);
    for (k = 0; k < 2; k++) begin
      repeat (3) offer_tick(quiet[0], quiet[1]);
      lv = pin_levels(1'b1, 1'b1);
      offer_tick(lv[0], lv[1]);
    end
    for (k = 0; k < 200; k++) begin
      offer_tick(quiet[0], quiet[1]);
    end
    run_phase(80);

    drain();
    repeat (4) @(posedge clk);
    $display("Decoded %0d ticks over %0d register settings; %0d results checked in %0d cycles.",
             ticks_sent, settings_done, results_seen, cycle_count);
    $display("Commands: open %0d, close %0d, stop %0d, open all %0d, close all %0d, stop all %0d.",
             cmd_seen[CMD_OPEN], cmd_seen[CMD_CLOSE], cmd_seen[CMD_STOP],
             cmd_seen[CMD_OPEN_ALL], cmd_seen[CMD_CLOSE_ALL], cmd_seen[CMD_STOP_ALL]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
